// ===== rtl/start_end_word_frame_resync_core_assert.svh =====
// Assertion macros used by the frame resync checker.
`ifndef START_END_WORD_FRAME_RESYNC_CORE_ASSERT_SVH
`define START_END_WORD_FRAME_RESYNC_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SWFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SWFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/swfr_pkg.sv =====
// Shared types and constants of the start/end word frame resync block.
`timescale 1ns / 1ps
package swfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 32;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_MARKER = 1'b0,
    REG_END_MARKER   = 1'b1
  } cfg_reg_t;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;   // input transfer: window moves one cell toward the head
    logic load;    // frame matched: copy the new window into the packet chain
    logic drain;   // output transfer: packet chain moves one cell toward the head
  } cell_ctrl_t;

endpackage

// ===== rtl/swfr_in_if.sv =====
// Received byte channel.
`timescale 1ns / 1ps
interface swfr_in_if;
  import swfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/swfr_out_if.sv =====
// Packet byte channel.
`timescale 1ns / 1ps
interface swfr_out_if;
  import swfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packet_byte;
  logic [IDX_W-1:0]  byte_index;
  logic              last_byte;

  modport source (output valid, output packet_byte, output byte_index, output last_byte,
                  input ready);
  modport sink   (input valid, input packet_byte, input byte_index, input last_byte,
                  output ready);
endinterface

// ===== rtl/start_end_word_frame_resync_core.sv =====
// Top level: fixed-length frame resync on start and end marker words.
//
//   channel  dir  handshake          payload
//   in_chan  in   valid / ready      rx_byte
//   out_chan out  valid / ready      packet_byte, byte_index, last_byte
//   cfg      in   cfg_we             cfg_idx, cfg_wdata
//
// One received byte per cycle unless held; a matched frame leaves as PACKET_BYTES
// transfers, one per cycle with out_ready high, the first in the cycle after
// the completing byte. Input is held only while a byte could complete a frame
// and the previous packet still has bytes that do not all leave in this cycle;
// the hold ends with the cycle in which that packet's last byte transfers.
// Reset (rst_n low, synchronous) clears the fill and packet counts, so the window
// and the packet chain read as empty, and clears both marker registers.
`timescale 1ns / 1ps
module start_end_word_frame_resync_core #(
  parameter int PACKET_BYTES = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  swfr_in_if.sink                        in_chan,
  swfr_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [swfr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [swfr_pkg::WORD_W-1:0]    cfg_wdata
);
  import swfr_pkg::*;

  logic [BYTE_W-1:0] win_q [PACKET_BYTES];
  logic [BYTE_W-1:0] pkt_q [PACKET_BYTES];
  cell_ctrl_t        ctrl;
  logic [WORD_W-1:0] head_word;
  logic [3*BYTE_W-1:0] tail_bytes;

  // cell 0 holds the oldest byte; new bytes enter at the far end.
  // The compare looks at the window as it will be after this shift.
  assign head_word  = {win_q[4], win_q[3], win_q[2], win_q[1]};
  assign tail_bytes = {win_q[PACKET_BYTES-1], win_q[PACKET_BYTES-2], win_q[PACKET_BYTES-3]};

  swfr_ctrl #(.PACKET_BYTES(PACKET_BYTES)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .rx_byte    (in_chan.rx_byte),
    .head_word  (head_word),
    .tail_bytes (tail_bytes),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .byte_index (out_chan.byte_index),
    .last_byte  (out_chan.last_byte),
    .ctrl       (ctrl)
  );

  for (genvar k = 0; k < PACKET_BYTES; k++) begin : g_cell
    logic [BYTE_W-1:0] win_in;
    logic [BYTE_W-1:0] pkt_in;

    if (k == PACKET_BYTES - 1) begin : g_end
      assign win_in = in_chan.rx_byte;
      assign pkt_in = '0;
    end else begin : g_mid
      assign win_in = win_q[k+1];
      assign pkt_in = pkt_q[k+1];
    end

    swfr_cell u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .win_in (win_in),
      .pkt_in (pkt_in),
      .win_q  (win_q[k]),
      .pkt_q  (pkt_q[k])
    );
  end

  assign out_chan.packet_byte = pkt_q[0];
endmodule

// ===== rtl/swfr_cell.sv =====
// One chain cell: a window byte and a packet byte, each shifted from the neighbor.
`timescale 1ns / 1ps
module swfr_cell (
  input  logic                        clk,
  input  swfr_pkg::cell_ctrl_t        ctrl,
  input  logic [swfr_pkg::BYTE_W-1:0] win_in,
  input  logic [swfr_pkg::BYTE_W-1:0] pkt_in,
  output logic [swfr_pkg::BYTE_W-1:0] win_q,
  output logic [swfr_pkg::BYTE_W-1:0] pkt_q
);
  import swfr_pkg::*;

  logic [BYTE_W-1:0] win_r;
  logic [BYTE_W-1:0] pkt_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      win_r <= win_in;
    end
  end

  // load only comes with a shift, so win_in is this cell's new window byte
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pkt_r <= win_in;
    end else if (ctrl.drain) begin
      pkt_r <= pkt_in;
    end
  end

  assign win_q = win_r;
  assign pkt_q = pkt_r;
endmodule

// ===== rtl/swfr_ctrl.sv =====
// Fill count, marker compare, packet drain count and handshakes.
`timescale 1ns / 1ps
module swfr_ctrl #(
  parameter int PACKET_BYTES = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [swfr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [swfr_pkg::WORD_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [swfr_pkg::BYTE_W-1:0]    rx_byte,
  input  logic [swfr_pkg::WORD_W-1:0]    head_word,
  input  logic [3*swfr_pkg::BYTE_W-1:0]  tail_bytes,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [swfr_pkg::IDX_W-1:0]     byte_index,
  output logic                           last_byte,
  output swfr_pkg::cell_ctrl_t           ctrl
);
  import swfr_pkg::*;

  localparam int FILL_W = $clog2(PACKET_BYTES);
  localparam int REM_W  = $clog2(PACKET_BYTES + 1);

  logic [WORD_W-1:0] start_r;
  logic [WORD_W-1:0] end_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              in_fire, out_fire, full_next, busy, match, load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_START_MARKER: start_r <= cfg_wdata;
        REG_END_MARKER:   end_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign full_next = (fill_r == FILL_W'(PACKET_BYTES - 1));
  assign busy      = (rem_r != '0);
  assign out_valid = busy;
  assign out_fire  = out_valid && out_ready;
  // hold input only when this byte could complete a frame while the previous
  // packet has not finished leaving
  assign in_ready  = !(full_next && busy && !(rem_r == REM_W'(1) && out_ready));
  assign in_fire   = in_valid && in_ready;

  assign match = full_next && (head_word == start_r) && ({rx_byte, tail_bytes} == end_r);
  assign load  = in_fire && match;

  always_comb begin
    fill_nxt = fill_r;
    if (in_fire) begin
      if (match) begin
        fill_nxt = '0;
      end else if (!full_next) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  always_comb begin
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (load) begin
      rem_nxt = REM_W'(PACKET_BYTES);
      idx_nxt = '0;
    end else if (out_fire) begin
      rem_nxt = rem_r - REM_W'(1);
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      rem_r  <= '0;
      idx_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      rem_r  <= rem_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign byte_index = idx_r;
  assign last_byte  = (rem_r == REM_W'(1));

  assign ctrl.shift = in_fire;
  assign ctrl.load  = load;
  assign ctrl.drain = out_fire;
endmodule

// ===== rtl/swfr_checker.sv =====
// Port-level checks of the frame resync block, bound to its top level.
`timescale 1ns / 1ps
`include "start_end_word_frame_resync_core_assert.svh"
module swfr_checker #(
  parameter int PACKET_BYTES = 32
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [swfr_pkg::BYTE_W-1:0] packet_byte,
  input logic [swfr_pkg::IDX_W-1:0]  byte_index,
  input logic                        last_byte
);
  import swfr_pkg::*;

  // the final byte sits at the packet's last position
  `SWFR_ASSERT_NOW(a_last_pos, out_valid && last_byte, byte_index == IDX_W'(PACKET_BYTES - 1), "last_byte away from final position")

  // a packet keeps flowing until its last byte
  `SWFR_ASSERT_NEXT(a_no_gap, out_valid && out_ready && !last_byte, out_valid, "packet broken off before last byte")

  // positions advance by one per transfer inside a packet
  `SWFR_ASSERT_NEXT(a_idx_step, out_valid && out_ready && !last_byte, byte_index == $past(byte_index) + IDX_W'(1), "byte_index skipped")

  // a stalled byte holds
  `SWFR_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(packet_byte) && $stable(byte_index), "stalled output changed")
endmodule

bind start_end_word_frame_resync_core swfr_checker #(.PACKET_BYTES(PACKET_BYTES)) u_swfr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .packet_byte (out_chan.packet_byte),
  .byte_index  (out_chan.byte_index),
  .last_byte   (out_chan.last_byte)
);
